### hdl/tcw_pkg.sv
// shared types, field widths and constants for the text console writer
// no dependencies; imported by every module of the block
package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // fixed widths of the item fields
    localparam int CHAR_W   = 8;
    localparam int COLOR_W  = 8;
    localparam int F_ROW_W  = 5;
    localparam int F_COL_W  = 7;

    localparam logic [CHAR_W-1:0]  NEWLINE_BYTE = 8'd10;
    localparam logic [CHAR_W-1:0]  SPACE_BYTE   = 8'h20;
    localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'd7;

    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [CHAR_W-1:0]  char_code;
        logic [F_ROW_W-1:0] read_row;
        logic [F_COL_W-1:0] read_col;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0]  cell_char;
        logic [COLOR_W-1:0] cell_color;
        logic [F_ROW_W-1:0] cursor_row;
        logic [F_COL_W-1:0] cursor_col;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic calc_row;
        logic calc_addr;
        logic sweep_addr;
        logic access;
        logic clr_wr;
        logic sweep_wr;
        logic out_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic sweep_last;
        logic scroll_need;
        logic out_free;
    } dp_status_t;

endpackage

### hdl/text_console_writer_top.sv
// top level of the text console writer: sequencer plus datapath
// depends on tcw_pkg, tcw_ctrl, tcw_datapath
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  in       | in_valid / in_ready  | in_data  (cmd, char_code, read_row/col)
//  out      | out_valid / out_ready| out_data (cell_char/color, cursor_row/col)
//  cfg      | cfg_wr_en            | cfg_wr_data (text colour attribute)
//
// a read or put steps through row, address and access, then loads the output register
// a put that moves past the last row also blanks the new bottom row in the sweep states;
// scrolling itself only rotates a base row register, no cells are moved
// after reset all ROWS * COLUMNS cells are cleared, one cell a cycle, without in_ready
// one item is in flight at a time; a result waiting on out_ready holds the next result back
module text_console_writer_top import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [COLOR_W-1:0] cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  in_item_t           in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output out_item_t          out_data
);

    dp_cmd_t    cmd;
    dp_status_t st;

    tcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cmd         (cmd),
        .st          (st)
    );

endmodule

### hdl/tcw_ctrl.sv
// sequencer for the text console writer: clearing pass, item steps, row blanking
// depends on tcw_pkg (dp_cmd_t, dp_status_t)
module tcw_ctrl import tcw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t st,
    output dp_cmd_t    cmd
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_ROW    = 3'd2;
    localparam logic [2:0] S_ADDR   = 3'd3;
    localparam logic [2:0] S_ACCESS = 3'd4;
    localparam logic [2:0] S_SADDR  = 3'd5;
    localparam logic [2:0] S_SWEEP  = 3'd6;
    localparam logic [2:0] S_RESULT = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (st.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_ROW;
                end
            end
            S_ROW:
            begin
                cmd.calc_row = 1'b1;
                state_next   = S_ADDR;
            end
            S_ADDR:
            begin
                cmd.calc_addr = 1'b1;
                state_next    = S_ACCESS;
            end
            S_ACCESS:
            begin
                cmd.access = 1'b1;
                state_next = st.scroll_need ? S_SADDR : S_RESULT;
            end
            S_SADDR:
            begin
                cmd.sweep_addr = 1'b1;
                state_next     = S_SWEEP;
            end
            S_SWEEP:
            begin
                cmd.sweep_wr = 1'b1;
                if (st.sweep_last)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### hdl/tcw_datapath.sv
// datapath for the text console writer: cell store, cursor, scroll base, result register
// depends on tcw_pkg (item structs, command and status structs, constants)
module tcw_datapath import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [COLOR_W-1:0] cfg_wr_data,
    input  in_item_t           in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output out_item_t          out_data,
    input  dp_cmd_t            cmd,
    output dp_status_t         st
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CELL_W = CHAR_W + COLOR_W;

    logic [CELL_W-1:0]  mem [CELLS];

    in_item_t           item_reg;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   base_reg, base_next;
    logic [COLOR_W-1:0] color_reg;
    logic [ROW_W-1:0]   phys_reg, phys_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [COL_W-1:0]   cnt_reg, cnt_next;
    logic [CELL_W-1:0]  rd_reg;
    out_item_t          out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    logic               is_read, is_put, is_nl, rd_ok, advance;
    logic [ROW_W-1:0]   row_sel;
    logic [ROW_W:0]     row_sum;
    logic [COL_W-1:0]   col_sel;
    logic               mem_we;
    logic [CELL_W-1:0]  mem_wdata;

    assign is_read = (item_reg.cmd == CMD_READ);
    assign is_put  = (item_reg.cmd == CMD_PUT);
    assign is_nl   = (item_reg.char_code == NEWLINE_BYTE);
    assign rd_ok   = (32'(item_reg.read_row) < 32'(ROWS))
                  && (32'(item_reg.read_col) < 32'(COLUMNS));
    assign advance = is_put && (is_nl || col_reg == COL_W'(COLUMNS - 1));

    assign st.scroll_need = advance && (row_reg == ROW_W'(ROWS - 1));
    assign st.clr_last    = (addr_reg == ADDR_W'(CELLS - 1));
    assign st.sweep_last  = (cnt_reg == COL_W'(COLUMNS - 1));
    assign st.out_free    = !out_valid_reg || out_ready;

    // logical row to physical row through the scroll base
    assign row_sel = is_read ? ROW_W'(item_reg.read_row) : row_reg;
    assign row_sum = {1'b0, row_sel} + {1'b0, base_reg};
    assign col_sel = cmd.sweep_addr ? '0 : (is_read ? COL_W'(item_reg.read_col) : col_reg);

    always_comb
    begin
        row_next       = row_reg;
        col_next       = col_reg;
        base_next      = base_reg;
        phys_next      = phys_reg;
        addr_next      = addr_reg;
        cnt_next       = cnt_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (cmd.calc_row)
        begin
            if (row_sum >= (ROW_W + 1)'(ROWS))
            begin
                phys_next = ROW_W'(row_sum - (ROW_W + 1)'(ROWS));
            end
            else
            begin
                phys_next = ROW_W'(row_sum);
            end
        end

        if (cmd.calc_addr || cmd.sweep_addr)
        begin
            addr_next = ADDR_W'(phys_reg) * ADDR_W'(COLUMNS) + ADDR_W'(col_sel);
        end
        else if (cmd.clr_wr || cmd.sweep_wr)
        begin
            addr_next = addr_reg + ADDR_W'(1);
        end

        if (cmd.sweep_addr)
        begin
            cnt_next = '0;
        end
        else if (cmd.sweep_wr)
        begin
            cnt_next = cnt_reg + COL_W'(1);
        end

        if (cmd.access && is_put)
        begin
            if (advance)
            begin
                col_next = '0;
                if (!st.scroll_need)
                begin
                    row_next = row_reg + ROW_W'(1);
                end
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end

        // scroll: rotate the base, the old top row becomes the blank bottom row
        if (cmd.access && st.scroll_need)
        begin
            phys_next = base_reg;
            if (base_reg == ROW_W'(ROWS - 1))
            begin
                base_next = '0;
            end
            else
            begin
                base_next = base_reg + ROW_W'(1);
            end
        end

        if (cmd.out_load)
        begin
            out_valid_next      = 1'b1;
            out_next.cell_char  = (is_read && rd_ok) ? rd_reg[CHAR_W-1:0] : '0;
            out_next.cell_color = (is_read && rd_ok) ? rd_reg[CELL_W-1:CHAR_W] : '0;
            out_next.cursor_row = F_ROW_W'(row_reg);
            out_next.cursor_col = F_COL_W'(col_reg);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_wdata = {color_reg, item_reg.char_code};
        if (cmd.clr_wr)
        begin
            mem_we    = 1'b1;
            mem_wdata = {RESET_COLOR, SPACE_BYTE};
        end
        else if (cmd.sweep_wr)
        begin
            mem_we    = 1'b1;
            mem_wdata = {color_reg, SPACE_BYTE};
        end
        else if (cmd.access && is_put && !is_nl)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[addr_reg] <= mem_wdata;
        end
        rd_reg <= mem[addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= in_data;
        end
        phys_reg <= phys_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            col_reg       <= '0;
            base_reg      <= '0;
            color_reg     <= RESET_COLOR;
            addr_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg       <= row_next;
            col_reg       <= col_next;
            base_reg      <= base_next;
            addr_reg      <= addr_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                color_reg <= cfg_wr_data;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(row_reg) < 32'(ROWS))
        else $error("cursor row beyond last row");

    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(col_reg) < 32'(COLUMNS))
        else $error("cursor column beyond last column");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result loaded over an untaken beat");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_item |=> !cmd.load_item)
        else $error("second item taken while one is in flight");

    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.access && st.scroll_need) |=>
            (row_reg == ROW_W'(ROWS - 1)) && (col_reg == '0))
        else $error("cursor not parked on last row after scroll");
`endif

endmodule
